// ===== hdl/bbspi_pkg.sv =====
// Package: access mode codes and the result item layout for the bit-banged SPI card interface.
`default_nettype none

package bbspi_pkg;

  localparam int unsigned ModeW = 5;

  localparam logic [ModeW-1:0] MODE_ENABLE    = 5'd0;
  localparam logic [ModeW-1:0] MODE_DISABLE   = 5'd1;
  localparam logic [ModeW-1:0] MODE_RESET     = 5'd2;
  localparam logic [ModeW-1:0] MODE_VERSION   = 5'd3;
  localparam logic [ModeW-1:0] MODE_READ      = 5'd4;
  localparam logic [ModeW-1:0] MODE_BG_ON_A   = 5'd5;
  localparam logic [ModeW-1:0] MODE_BG_ON_B   = 5'd6;
  localparam logic [ModeW-1:0] MODE_BG_OFF    = 5'd7;
  localparam logic [ModeW-1:0] MODE_SEL0      = 5'd8;
  localparam logic [ModeW-1:0] MODE_SEL1      = 5'd9;
  localparam logic [ModeW-1:0] MODE_SEL2      = 5'd10;
  localparam logic [ModeW-1:0] MODE_SEL3      = 5'd11;
  localparam logic [ModeW-1:0] MODE_MOSI_CLR  = 5'd12;
  localparam logic [ModeW-1:0] MODE_MOSI_SET  = 5'd13;
  localparam logic [ModeW-1:0] MODE_SCLK_CLR  = 5'd14;
  localparam logic [ModeW-1:0] MODE_SCLK_SET  = 5'd15;
  localparam logic [ModeW-1:0] MODE_BG_XFER   = 5'd16;

  // card_select codes
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_CARD0 = 2'd1;
  localparam logic [1:0] SEL_CARD1 = 2'd2;

  localparam logic [7:0] MsbMask = 8'h80;

  // Result item, lowest field in the lowest bits
  typedef struct packed {
    logic       bad_select;
    logic       card_index;
    logic       card_fetch;
    logic [7:0] send_byte;
    logic       card_send;
    logic [7:0] read_data;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bit_banged_spi_card_interface.sv =====
// Top level: bit-banged SPI card interface with byte-wide background transfer mode.
`default_nettype none

// Each input item is one host read access, selected by the mode code in s_axis_tuser_i.
// The access is decoded against the interface state (enable, select, MOSI/SCLK levels,
// shift registers and bit counters) combinationally: the state updates at the edge the
// item is accepted and the result item lands in the output register at that same edge.
// One item is taken per cycle unless a full output register is stalled; that register
// is the only stage, so a new item is accepted whenever it is empty or being drained in
// the same cycle. Result tvalid rises the cycle after accept. Every access yields exactly
// one result item. Rising SCLK with a card selected shifts MOSI into the outgoing byte
// and every eighth bit delivers it (card_send). Falling SCLK fetches a card byte on the
// first edge of each group of eight (card_fetch) and shifts left on the others. A read
// returns 0xFF or 0x00 from the incoming byte MSB, or the last background byte when
// background mode is on. Select code 3 deselects. A background transfer with no card
// selected is suppressed and flags bad_select.
module bit_banged_spi_card_interface
  import bbspi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [7:0] tx_byte, [15:8] card_byte
  input  wire logic [4:0]  s_axis_tuser_i,  // [4:0] mode
  // result item
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o   // [7:0] read_data, [8] card_send,
                                            // [16:9] send_byte, [17] card_fetch,
                                            // [18] card_index, [19] bad_select, rest 0
);

  // Interface state
  logic       enabled_q, enabled_d;
  logic       bg_mode_q, bg_mode_d;
  logic [1:0] sel_q, sel_d;
  logic       mosi_q, mosi_d;
  logic       sclk_q, sclk_d;
  logic [2:0] out_cnt_q, out_cnt_d;
  logic [2:0] in_cnt_q, in_cnt_d;
  logic [7:0] out_sh_q, out_sh_d;
  logic [7:0] in_sh_q, in_sh_d;
  logic [7:0] bg_rd_q, bg_rd_d;

  // Output register
  logic    out_vld_q;
  result_t res_q, res_d;

  logic [ModeW-1:0] mode;
  logic [7:0]       tx_byte;
  logic [7:0]       card_byte;
  logic             accept;
  logic             card_idx;  // selected card, select code minus one
  logic [7:0]       out_sh_nxt;

  assign mode      = s_axis_tuser_i;
  assign tx_byte   = s_axis_tdata_i[7:0];
  assign card_byte = s_axis_tdata_i[15:8];

  // Skid-free single stage: take a new item whenever the result slot frees up
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign card_idx   = sel_q[1];  // SEL_CARD0 -> 0, SEL_CARD1 -> 1
  assign out_sh_nxt = {out_sh_q[6:0], mosi_q};

  always_comb begin
    enabled_d = enabled_q;
    bg_mode_d = bg_mode_q;
    sel_d     = sel_q;
    mosi_d    = mosi_q;
    sclk_d    = sclk_q;
    out_cnt_d = out_cnt_q;
    in_cnt_d  = in_cnt_q;
    out_sh_d  = out_sh_q;
    in_sh_d   = in_sh_q;
    bg_rd_d   = bg_rd_q;
    res_d     = '0;

    if (mode == MODE_ENABLE) begin
      enabled_d = 1'b1;
    end else if (mode == MODE_BG_XFER && bg_mode_q) begin
      // whole-byte exchange, works even while disabled
      if (sel_q != SEL_NONE) begin
        res_d.card_index = card_idx;
        res_d.card_send  = 1'b1;
        res_d.send_byte  = tx_byte;
        res_d.card_fetch = 1'b1;
        bg_rd_d          = card_byte;
      end else begin
        res_d.bad_select = 1'b1;
      end
    end else if (enabled_q) begin
      unique case (mode) inside
        MODE_DISABLE: enabled_d = 1'b0;
        MODE_RESET: begin
          sel_d     = SEL_NONE;
          mosi_d    = 1'b0;
          sclk_d    = 1'b0;
          out_cnt_d = '0;
          in_cnt_d  = '0;
          out_sh_d  = '0;
          in_sh_d   = '0;
          bg_mode_d = 1'b0;
        end
        MODE_READ: begin
          if (bg_mode_q) begin
            res_d.read_data = bg_rd_q;
          end else begin
            res_d.read_data = ((in_sh_q & MsbMask) != '0) ? 8'hFF : 8'h00;
          end
        end
        MODE_BG_ON_A, MODE_BG_ON_B: bg_mode_d = 1'b1;
        MODE_BG_OFF:                bg_mode_d = 1'b0;
        MODE_SEL0, MODE_SEL3:       sel_d = SEL_NONE;
        MODE_SEL1:                  sel_d = SEL_CARD0;
        MODE_SEL2:                  sel_d = SEL_CARD1;
        MODE_MOSI_CLR:              mosi_d = 1'b0;
        MODE_MOSI_SET:              mosi_d = 1'b1;
        MODE_SCLK_CLR: begin
          // falling edge: fetch on first bit of a group, shift on the rest
          if (sclk_q && sel_q != SEL_NONE) begin
            if (in_cnt_q == '0) begin
              in_sh_d          = card_byte;
              res_d.card_fetch = 1'b1;
              res_d.card_index = card_idx;
            end else begin
              in_sh_d = {in_sh_q[6:0], 1'b0};
            end
            in_cnt_d = in_cnt_q + 3'd1;
          end
          sclk_d = 1'b0;
        end
        MODE_SCLK_SET: begin
          // rising edge: shift MOSI in, deliver byte on the eighth bit
          if (!sclk_q && sel_q != SEL_NONE) begin
            out_sh_d = out_sh_nxt;
            if (out_cnt_q == 3'd7) begin
              res_d.card_send  = 1'b1;
              res_d.send_byte  = out_sh_nxt;
              res_d.card_index = card_idx;
            end
            out_cnt_d = out_cnt_q + 3'd1;  // wraps to zero after a byte
          end
          sclk_d = 1'b1;
        end
        default: ;  // version, background transfer with mode off, unknown codes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      bg_mode_q <= 1'b0;
      sel_q     <= SEL_NONE;
      mosi_q    <= 1'b0;
      sclk_q    <= 1'b0;
      out_cnt_q <= '0;
      in_cnt_q  <= '0;
      out_sh_q  <= '0;
      in_sh_q   <= '0;
      bg_rd_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        enabled_q <= enabled_d;
        bg_mode_q <= bg_mode_d;
        sel_q     <= sel_d;
        mosi_q    <= mosi_d;
        sclk_q    <= sclk_d;
        out_cnt_q <= out_cnt_d;
        in_cnt_q  <= in_cnt_d;
        out_sh_q  <= out_sh_d;
        in_sh_q   <= in_sh_d;
        bg_rd_q   <= bg_rd_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, res_q};

endmodule

`default_nettype wire

// ===== tb/spi_card_checker.sv =====
// Checker: tracks the card interface state, predicts each result item and compares it.
module spi_card_checker
  import bbspi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [15:0]       in_data_i,     // [7:0] tx_byte, [15:8] card_byte
  input  logic [ModeW-1:0]  in_mode_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [23:0]       out_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  // shadow copy of the interface state
  logic       enabled;
  logic       bg_mode;
  logic [1:0] sel;
  logic       mosi;
  logic       sclk;
  logic [2:0] out_cnt;
  logic [2:0] in_cnt;
  logic [7:0] out_sr;
  logic [7:0] in_sr;
  logic [7:0] bg_byte;

  result_t awaited[$];

  function automatic void drop_link();
    sel     = SEL_NONE;
    mosi    = 1'b0;
    sclk    = 1'b0;
    out_cnt = '0;
    in_cnt  = '0;
    out_sr  = '0;
    in_sr   = '0;
    bg_mode = 1'b0;
  endfunction

  // One host access: updates the shadow state, returns the result item it yields.
  function automatic result_t spi_access(input logic [ModeW-1:0] mode,
                                         input logic [7:0] tx, input logic [7:0] cb);
    result_t r;
    r = '0;
    if (mode == MODE_ENABLE) begin
      enabled = 1'b1;
    end else if (mode == MODE_BG_XFER && bg_mode) begin
      // byte-wide exchange, works even with the interface disabled
      if (sel != SEL_NONE) begin
        r.card_index = (sel == SEL_CARD1);
        r.card_send  = 1'b1;
        r.send_byte  = tx;
        r.card_fetch = 1'b1;
        bg_byte      = cb;
      end else begin
        r.bad_select = 1'b1;
      end
    end else if (enabled) begin
      case (mode)
        MODE_DISABLE:               enabled = 1'b0;
        MODE_RESET:                 drop_link();
        MODE_READ: begin
          if (bg_mode) r.read_data = bg_byte;
          else         r.read_data = ((in_sr & MsbMask) != 0) ? 8'hFF : 8'h00;
        end
        MODE_BG_ON_A, MODE_BG_ON_B: bg_mode = 1'b1;
        MODE_BG_OFF:                bg_mode = 1'b0;
        MODE_SEL0, MODE_SEL3:       sel = SEL_NONE;
        MODE_SEL1:                  sel = SEL_CARD0;
        MODE_SEL2:                  sel = SEL_CARD1;
        MODE_MOSI_CLR:              mosi = 1'b0;
        MODE_MOSI_SET:              mosi = 1'b1;
        MODE_SCLK_CLR: begin
          // falling edge: fetch on the first of eight, shift on the rest
          if (sclk && sel != SEL_NONE) begin
            if (in_cnt == 3'd0) begin
              in_sr        = cb;
              r.card_fetch = 1'b1;
              r.card_index = (sel == SEL_CARD1);
            end else begin
              in_sr = in_sr << 1;
            end
            in_cnt = in_cnt + 3'd1;
          end
          sclk = 1'b0;
        end
        MODE_SCLK_SET: begin
          // rising edge: shift MOSI in, eighth bit delivers the byte
          if (!sclk && sel != SEL_NONE) begin
            out_sr = {out_sr[6:0], mosi};
            if (out_cnt == 3'd7) begin
              r.card_send  = 1'b1;
              r.send_byte  = out_sr;
              r.card_index = (sel == SEL_CARD1);
            end
            out_cnt = out_cnt + 3'd1;
          end
          sclk = 1'b1;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_miss(input string why, input result_t want, input logic [23:0] got);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("%0t: %s: expected rd=%h snd=%b sb=%h fet=%b idx=%b bad=%b, got tdata=%h",
               $realtime, why, want.read_data, want.card_send, want.send_byte,
               want.card_fetch, want.card_index, want.bad_select, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      drop_link();
      enabled      = 1'b0;
      bg_byte      = '0;
      awaited.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // retire first: the item accepted now was predicted at an earlier edge
      if (out_valid_i && out_ready_i) begin
        seen = out_data_i[19:0];
        if (awaited.size() == 0) begin
          report_miss("result with nothing pending", '0, out_data_i);
        end else begin
          want = awaited.pop_front();
          if (seen.read_data  !== want.read_data  || seen.card_send  !== want.card_send  ||
              seen.send_byte  !== want.send_byte  || seen.card_fetch !== want.card_fetch ||
              seen.card_index !== want.card_index || seen.bad_select !== want.bad_select ||
              out_data_i[23:20] !== 4'b0)
            report_miss("result mismatch", want, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i)
        awaited.push_back(spi_access(in_mode_i, in_data_i[7:0], in_data_i[15:8]));
      pending_o = awaited.size();
    end
  end

endmodule

// ===== tb/bit_banged_spi_card_interface_test.sv =====
// Testbench top: drives host accesses and the result stall pattern, then gives the verdict.
module bit_banged_spi_card_interface_test;
  import bbspi_pkg::*;

  localparam logic [ModeW-1:0] MODE_FIRST_UNUSED = 5'd17;
  localparam logic [ModeW-1:0] MODE_LAST_UNUSED  = 5'd31;
  localparam int unsigned      ACCESS_TOTAL      = 1850;
  localparam int unsigned      CALM_FROM         = 1650;  // no idling past this point
  localparam int unsigned      SQUEEZE_AT        = 600;   // long result stall starts here
  localparam int unsigned      SQUEEZE_LEN       = 300;

  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;
  logic [ModeW-1:0]  s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned accesses_sent = 0;
  bit          calm          = 1'b0;
  bit          squeezed      = 1'b0;

  always #5 clk = ~clk;

  bit_banged_spi_card_interface uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  spi_card_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .in_mode_i    (s_tuser),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Offer one access; optional idle burst first. Returns once the item is taken.
  task automatic send_access(input logic [ModeW-1:0] mode, input logic [7:0] tx,
                             input logic [7:0] cb);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {cb, tx};
    do @(posedge clk); while (!s_tready);
    accesses_sent++;
  endtask

  task automatic send_mode(input logic [ModeW-1:0] mode);
    send_access(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Enable (usually), select a card, clock out 1..3 bytes bit by bit with reads mixed in.
  task automatic bang_bytes();
    int unsigned nbytes;
    logic [7:0]  pattern;
    if ($urandom_range(0, 9) != 0) send_mode(MODE_ENABLE);
    if ($urandom_range(0, 3) != 0) send_mode(MODE_BG_OFF);
    send_mode($urandom_range(0, 1) ? MODE_SEL1 : MODE_SEL2);
    nbytes = $urandom_range(1, 3);
    repeat (nbytes) begin
      pattern = 8'($urandom_range(0, 255));
      for (int b = 7; b >= 0; b--) begin
        send_mode(pattern[b] ? MODE_MOSI_SET : MODE_MOSI_CLR);
        send_mode(MODE_SCLK_SET);
        if ($urandom_range(0, 3) == 0) send_mode(MODE_READ);
        send_mode(MODE_SCLK_CLR);
      end
    end
    case ($urandom_range(0, 3))
      0:       send_mode(MODE_SEL0);
      1:       send_mode(MODE_SEL3);
      2:       send_mode(MODE_RESET);
      default: ;
    endcase
  endtask

  // Byte-wide exchanges; now and then with no card selected.
  task automatic background_burst();
    int unsigned n;
    if ($urandom_range(0, 9) != 0) send_mode(MODE_ENABLE);
    send_mode($urandom_range(0, 1) ? MODE_BG_ON_A : MODE_BG_ON_B);
    case ($urandom_range(0, 5))
      0:       send_mode(MODE_SEL0);
      1:       send_mode(MODE_SEL3);
      2, 3:    send_mode(MODE_SEL1);
      default: send_mode(MODE_SEL2);
    endcase
    n = $urandom_range(1, 8);
    repeat (n) begin
      send_mode(MODE_BG_XFER);
      if ($urandom_range(0, 2) == 0) send_mode(MODE_READ);
    end
    if ($urandom_range(0, 1) == 0) send_mode(MODE_BG_OFF);
  endtask

  // Result side: random stall bursts, plus one long hold so the block backs up.
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (!squeezed && accesses_sent >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned waited;
    int unsigned pick;
    int unsigned n;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: disabled behavior, background corner cases, clock levels, every code
    send_access(MODE_READ,     8'hFF, 8'hFF);   // disabled, returns zeros
    send_access(MODE_BG_XFER,  8'hFF, 8'hFF);   // background off: acts as unknown
    send_access(MODE_ENABLE,   8'h00, 8'h00);
    send_access(MODE_VERSION,  8'hFF, 8'hFF);
    send_access(MODE_BG_ON_A,  8'h00, 8'h00);
    send_access(MODE_BG_XFER,  8'hA5, 8'h5A);   // no card selected
    send_access(MODE_SEL1,     8'h00, 8'h00);
    send_access(MODE_BG_XFER,  8'hFF, 8'h00);
    send_access(MODE_READ,     8'h00, 8'h00);
    send_access(MODE_SEL2,     8'h00, 8'h00);
    send_access(MODE_BG_XFER,  8'h00, 8'hFF);
    send_access(MODE_DISABLE,  8'h00, 8'h00);
    send_access(MODE_BG_XFER,  8'hA5, 8'h5A);   // still runs while disabled
    send_access(MODE_ENABLE,   8'h00, 8'h00);
    send_access(MODE_READ,     8'h00, 8'h00);
    send_access(MODE_BG_ON_B,  8'h00, 8'h00);
    send_access(MODE_BG_OFF,   8'h00, 8'h00);
    send_access(MODE_SEL3,     8'h00, 8'h00);   // deselects
    send_access(MODE_SCLK_SET, 8'h00, 8'hFF);   // edge with no card
    send_access(MODE_SCLK_SET, 8'h00, 8'hFF);   // same level again
    send_access(MODE_SCLK_CLR, 8'h00, 8'hFF);
    send_access(MODE_SCLK_CLR, 8'h00, 8'hFF);
    send_access(MODE_FIRST_UNUSED, 8'hFF, 8'hFF);
    send_access(MODE_LAST_UNUSED,  8'hFF, 8'hFF);
    send_access(MODE_SEL0,     8'h00, 8'h00);
    send_access(MODE_MOSI_SET, 8'h00, 8'h00);
    send_access(MODE_MOSI_CLR, 8'h00, 8'h00);
    send_access(MODE_RESET,    8'h00, 8'h00);

    // random: mostly well-formed transfers, some raw noise
    while (accesses_sent < ACCESS_TOTAL) begin
      calm = (accesses_sent >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        bang_bytes();
      end else if (pick < 85) begin
        background_burst();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_mode(ModeW'($urandom_range(0, MODE_LAST_UNUSED)));
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);

    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bbspi_pkg.sv
hdl/bit_banged_spi_card_interface.sv
tb/spi_card_checker.sv
tb/bit_banged_spi_card_interface_test.sv
